### rtl/steering_force_unit_macros.svh
// Assertion macros shared by the steering force unit checkers.
`ifndef STEERING_FORCE_UNIT_MACROS_SVH
`define STEERING_FORCE_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SFU_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SFU_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### rtl/sfu_pkg.sv
// Types, constants and fixed-point helpers of the steering force unit.
package sfu_pkg;

  // Steering commands
  typedef enum logic [2:0] {
    CMD_SEEK       = 3'd0,
    CMD_FLEE       = 3'd1,
    CMD_ARRIVE     = 3'd2,
    CMD_PURSUE     = 3'd3,
    CMD_EVADE      = 3'd4,
    CMD_OFS_PURSUE = 3'd5,
    CMD_OFS_ARRIVE = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_SPEED_MAX = 1'b0;
  localparam logic REG_FORCE_MAX = 1'b1;

  localparam logic [30:0] REG_RESET  = 31'd65536;
  localparam logic [31:0] ARRIVE_EPS = 32'd7;       // 0.0001 on the Q16.16 grid
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic [40:0] QUOT_LIMIT = 41'h100_0000_0000;  // 2^40

  localparam logic signed [43:0] SAT_HI = 44'sd2147483647;
  localparam logic signed [43:0] SAT_LO = -44'sd2147483648;

  // Everything an item carries down the pipeline
  typedef struct packed {
    cmd_t              cmd;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] svx;
    logic signed [31:0] svy;
    logic [30:0]        standoff;
    logic [30:0]        slow;
    logic signed [31:0] px;     // base / target point, later desired velocity
    logic signed [31:0] py;
    logic signed [31:0] dx;     // working vector
    logic signed [31:0] dy;
    logic [31:0]        mag;    // magnitude of the working vector
    logic [31:0]        speed;
    logic               ok;
  } item_t;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > SAT_HI) return 32'sh7FFF_FFFF;
    else if (v < SAT_LO) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // Apply a sign to a clamped quotient
  function automatic logic signed [43:0] signed_q(input logic [40:0] q, input logic neg);
    logic signed [43:0] e;
    e = signed'({3'b000, q});
    return neg ? -e : e;
  endfunction

  // Magnitude of a signed 32-bit value
  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Limit a quotient to 2^40
  function automatic logic [40:0] clamp_q(input logic [63:0] q);
    return (q > 64'(QUOT_LIMIT)) ? QUOT_LIMIT : q[40:0];
  endfunction

endpackage

### rtl/sfu_mag.sv
// Pipelined vector magnitude: floor(sqrt(x*x + y*y)), one result bit per stage.
module sfu_mag #(
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  x,
  input  logic signed [31:0]  y,
  input  logic [SW-1:0]       side_in,
  output logic                out_valid,
  output logic [31:0]         mag,
  output logic [SW-1:0]       side_out
);

  logic [63:0]   sqx, sqy;
  logic          v_sq;
  logic [SW-1:0] side_sq;

  logic [63:0]   rem  [0:32];
  logic [31:0]   root [0:32];
  logic          vld  [0:32];
  logic [SW-1:0] sd   [0:32];

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq <= 1'b0;
    end else if (en) begin
      v_sq <= in_valid;
    end
    if (en) begin
      sqx     <= 64'(sfu_pkg::abs32(x)) * 64'(sfu_pkg::abs32(x));
      sqy     <= 64'(sfu_pkg::abs32(y)) * 64'(sfu_pkg::abs32(y));
      side_sq <= side_in;
    end
  end

  // sum of squares; fits 64 bits since each square is at most 2^62
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v_sq;
    end
    if (en) begin
      rem[0]  <= sqx + sqy;
      root[0] <= '0;
      sd[0]   <= side_sq;
    end
  end

  // digit-by-digit square root, bit 31 first
  for (genvar g = 0; g < 32; g++) begin : g_root
    localparam int I = 31 - g;
    logic [63:0] trial;
    assign trial = (64'(root[g]) << (I + 1)) + (64'd1 << (2 * I));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        sd[g+1] <= sd[g];
        if (rem[g] >= trial) begin
          rem[g+1]  <= rem[g] - trial;
          root[g+1] <= root[g] | (32'd1 << I);
        end else begin
          rem[g+1]  <= rem[g];
          root[g+1] <= root[g];
        end
      end
    end
  end

  assign out_valid = vld[32];
  assign mag       = root[32];
  assign side_out  = sd[32];

endmodule

### rtl/sfu_muldiv.sv
// Pipelined two-lane a*num/den and b*num/den, one quotient bit per stage.
module sfu_muldiv #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  logic [31:0]   num,
  input  logic [31:0]   den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [40:0]   qa,
  output logic [40:0]   qb,
  output logic [SW-1:0] side_out
);

  logic [63:0]   wa  [0:64];   // dividend shifting out, quotient shifting in
  logic [63:0]   wb  [0:64];
  logic [31:0]   ra  [0:64];
  logic [31:0]   rb  [0:64];
  logic [31:0]   dn  [0:64];
  logic          vld [0:64];
  logic [SW-1:0] sd  [0:64];

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      wa[0] <= 64'(a) * 64'(num);
      wb[0] <= 64'(b) * 64'(num);
      ra[0] <= '0;
      rb[0] <= '0;
      dn[0] <= den;
      sd[0] <= side_in;
    end
  end

  // restoring division, MSB first
  for (genvar g = 0; g < 64; g++) begin : g_div
    logic [32:0] ta, tb;
    logic        ga, gb;
    assign ta = {ra[g], wa[g][63]};
    assign tb = {rb[g], wb[g][63]};
    assign ga = ta >= {1'b0, dn[g]};
    assign gb = tb >= {1'b0, dn[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
      if (en) begin
        ra[g+1] <= ga ? 32'(ta - {1'b0, dn[g]}) : ta[31:0];
        rb[g+1] <= gb ? 32'(tb - {1'b0, dn[g]}) : tb[31:0];
        wa[g+1] <= {wa[g][62:0], ga};
        wb[g+1] <= {wb[g][62:0], gb};
        dn[g+1] <= dn[g];
        sd[g+1] <= sd[g];
      end
    end
  end

  assign out_valid = vld[64];
  assign qa        = sfu_pkg::clamp_q(wa[64]);
  assign qb        = sfu_pkg::clamp_q(wb[64]);
  assign side_out  = sd[64];

endmodule

### rtl/steering_force_unit.sv
// Steering force unit: takes one agent per cycle (seek, flee, arrival, pursuit,
// evasion and the two offset modes) and returns its clamped steering force in
// signed Q16.16, one transaction out for each transaction in, in order. The
// datapath is one flat pipeline: four magnitude units (square, sum, 32 square-root
// stages) and five multiply-divide units (product, 64 quotient stages) in series,
// joined by eight register stages of unpack, add, saturate and select, the last of
// them the output register. Throughput is one item per cycle; the whole pipeline
// holds while a result waits at the output. The user must write configuration only
// while no item is in flight; the block itself does not enforce this.
module steering_force_unit (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[2:0], target_x, target_y, target_vx, target_vy, source_x, source_y,
  // source_vx, source_vy (32 each), standoff[30:0], slowing_distance[30:0], zero pad
  input  logic [327:0] s_tdata,
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // force_x[31:0], force_y[63:32]
  output logic         m_tuser   // computed
);

  localparam int IW = $bits(sfu_pkg::item_t);

  logic [30:0] speed_cap, force_cap;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_cap <= sfu_pkg::REG_RESET;
      force_cap <= sfu_pkg::REG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sfu_pkg::REG_SPEED_MAX: speed_cap <= cfg_data;
        default:                force_cap <= cfg_data;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage A: unpack, target minus source
  sfu_pkg::item_t it_in, it_a;
  logic           va;

  always_comb begin
    it_in          = '0;
    it_in.cmd      = sfu_pkg::cmd_t'(s_tdata[2:0]);
    it_in.tx       = s_tdata[34:3];
    it_in.ty       = s_tdata[66:35];
    it_in.tvx      = s_tdata[98:67];
    it_in.tvy      = s_tdata[130:99];
    it_in.sx       = s_tdata[162:131];
    it_in.sy       = s_tdata[194:163];
    it_in.svx      = s_tdata[226:195];
    it_in.svy      = s_tdata[258:227];
    it_in.standoff = s_tdata[289:259];
    it_in.slow     = s_tdata[320:290];
    it_in.dx       = sfu_pkg::sat32(44'(it_in.tx) - 44'(it_in.sx));
    it_in.dy       = sfu_pkg::sat32(44'(it_in.ty) - 44'(it_in.sy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
    if (en) it_a <= it_in;
  end

  // ---------------- distance to target, then lead time
  logic [IW-1:0]  side_b, side_c;
  sfu_pkg::item_t it_b, it_c, md_a_side;
  logic [31:0]    mag_b;
  logic           vb, vc;
  logic [40:0]    qa_x, qa_y;

  sfu_mag #(.SW(IW)) u_mag_a (
    .clk, .rst, .en, .in_valid(va), .x(it_a.dx), .y(it_a.dy), .side_in(it_a),
    .out_valid(vb), .mag(mag_b), .side_out(side_b)
  );
  assign it_b = sfu_pkg::item_t'(side_b);

  always_comb begin
    md_a_side     = it_b;
    md_a_side.mag = mag_b;
  end

  sfu_muldiv #(.SW(IW)) u_md_lead (
    .clk, .rst, .en, .in_valid(vb),
    .a(sfu_pkg::abs32(it_b.tvx)), .b(sfu_pkg::abs32(it_b.tvy)),
    .num(mag_b), .den({1'b0, speed_cap}), .side_in(md_a_side),
    .out_valid(vc), .qa(qa_x), .qb(qa_y), .side_out(side_c)
  );
  assign it_c = sfu_pkg::item_t'(side_c);

  // ---------------- stage P: predicted point, base point, vector to source
  sfu_pkg::item_t it_p, it_d;
  logic           vd;

  always_comb begin
    logic signed [31:0] pred_x, pred_y;
    it_p = it_c;
    if (speed_cap == '0) begin
      pred_x = it_c.tx;
      pred_y = it_c.ty;
    end else begin
      pred_x = sfu_pkg::sat32(44'(it_c.tx) + sfu_pkg::signed_q(qa_x, it_c.tvx[31]));
      pred_y = sfu_pkg::sat32(44'(it_c.ty) + sfu_pkg::signed_q(qa_y, it_c.tvy[31]));
    end
    if (it_c.cmd inside {sfu_pkg::CMD_PURSUE, sfu_pkg::CMD_EVADE, sfu_pkg::CMD_OFS_PURSUE}) begin
      it_p.px = pred_x;
      it_p.py = pred_y;
    end else begin
      it_p.px = it_c.tx;
      it_p.py = it_c.ty;
    end
    it_p.dx = sfu_pkg::sat32(44'(it_c.sx) - 44'(it_p.px));
    it_p.dy = sfu_pkg::sat32(44'(it_c.sy) - 44'(it_p.py));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
    if (en) it_d <= it_p;
  end

  // ---------------- offset direction scaled to standoff
  logic [IW-1:0]  side_e, side_f;
  sfu_pkg::item_t it_e, it_f, md_b_side;
  logic [31:0]    mag_e;
  logic           ve, vf;
  logic [40:0]    qb_x, qb_y;

  sfu_mag #(.SW(IW)) u_mag_b (
    .clk, .rst, .en, .in_valid(vd), .x(it_d.dx), .y(it_d.dy), .side_in(it_d),
    .out_valid(ve), .mag(mag_e), .side_out(side_e)
  );
  assign it_e = sfu_pkg::item_t'(side_e);

  always_comb begin
    md_b_side     = it_e;
    md_b_side.mag = mag_e;
  end

  sfu_muldiv #(.SW(IW)) u_md_ofs (
    .clk, .rst, .en, .in_valid(ve),
    .a(sfu_pkg::abs32(it_e.dx)), .b(sfu_pkg::abs32(it_e.dy)),
    .num({1'b0, it_e.standoff}), .den(mag_e), .side_in(md_b_side),
    .out_valid(vf), .qa(qb_x), .qb(qb_y), .side_out(side_f)
  );
  assign it_f = sfu_pkg::item_t'(side_f);

  // ---------------- stage Q1: offset point
  sfu_pkg::item_t it_q1, it_g;
  logic           vg;

  always_comb begin
    logic signed [31:0] off_x, off_y;
    it_q1 = it_f;
    if (it_f.mag >= sfu_pkg::ARRIVE_EPS) begin
      off_x = sfu_pkg::sat32(sfu_pkg::signed_q(qb_x, it_f.dx[31]));
      off_y = sfu_pkg::sat32(sfu_pkg::signed_q(qb_y, it_f.dy[31]));
    end else begin
      off_x = '0;
      off_y = sfu_pkg::ONE_Q16;
    end
    if (it_f.cmd inside {sfu_pkg::CMD_OFS_PURSUE, sfu_pkg::CMD_OFS_ARRIVE}) begin
      it_q1.px = sfu_pkg::sat32(44'(it_f.px) + 44'(off_x));
      it_q1.py = sfu_pkg::sat32(44'(it_f.py) + 44'(off_y));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (en) begin
      vg <= vf;
    end
    if (en) it_g <= it_q1;
  end

  // ---------------- stage Q2: steering vector, toward or away
  sfu_pkg::item_t it_q2, it_h;
  logic           vh;

  always_comb begin
    it_q2 = it_g;
    if (it_g.cmd inside {sfu_pkg::CMD_FLEE, sfu_pkg::CMD_EVADE}) begin
      it_q2.dx = sfu_pkg::sat32(44'(it_g.sx) - 44'(it_g.px));
      it_q2.dy = sfu_pkg::sat32(44'(it_g.sy) - 44'(it_g.py));
    end else begin
      it_q2.dx = sfu_pkg::sat32(44'(it_g.px) - 44'(it_g.sx));
      it_q2.dy = sfu_pkg::sat32(44'(it_g.py) - 44'(it_g.sy));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else if (en) begin
      vh <= vg;
    end
    if (en) it_h <= it_q2;
  end

  // ---------------- distance, then arrival speed
  logic [IW-1:0]  side_i, side_j;
  sfu_pkg::item_t it_i, it_j, md_c_side;
  logic [31:0]    mag_i;
  logic           vi, vj;
  logic [40:0]    qs, qs_unused;

  sfu_mag #(.SW(IW)) u_mag_c (
    .clk, .rst, .en, .in_valid(vh), .x(it_h.dx), .y(it_h.dy), .side_in(it_h),
    .out_valid(vi), .mag(mag_i), .side_out(side_i)
  );
  assign it_i = sfu_pkg::item_t'(side_i);

  always_comb begin
    md_c_side     = it_i;
    md_c_side.mag = mag_i;
  end

  sfu_muldiv #(.SW(IW)) u_md_speed (
    .clk, .rst, .en, .in_valid(vi),
    .a(mag_i), .b('0), .num({1'b0, speed_cap}), .den({1'b0, it_i.slow}),
    .side_in(md_c_side),
    .out_valid(vj), .qa(qs), .qb(qs_unused), .side_out(side_j)
  );
  assign it_j = sfu_pkg::item_t'(side_j);

  // ---------------- stage S: speed select and produce flag
  sfu_pkg::item_t it_s, it_k;
  logic           vk;

  always_comb begin
    logic arr;
    it_s = it_j;
    arr  = it_j.cmd inside {sfu_pkg::CMD_ARRIVE, sfu_pkg::CMD_OFS_ARRIVE};
    it_s.ok = arr ? (it_j.mag >= sfu_pkg::ARRIVE_EPS) : (it_j.cmd != sfu_pkg::CMD_NOP);
    if (arr && it_j.slow != '0 && it_j.mag < {1'b0, it_j.slow}) begin
      it_s.speed = qs[31:0];
    end else begin
      it_s.speed = {1'b0, speed_cap};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vk <= 1'b0;
    end else if (en) begin
      vk <= vj;
    end
    if (en) it_k <= it_s;
  end

  // ---------------- desired velocity scale
  logic [IW-1:0]  side_l;
  sfu_pkg::item_t it_l;
  logic           vl;
  logic [40:0]    qd_x, qd_y;

  sfu_muldiv #(.SW(IW)) u_md_desired (
    .clk, .rst, .en, .in_valid(vk),
    .a(sfu_pkg::abs32(it_k.dx)), .b(sfu_pkg::abs32(it_k.dy)),
    .num(it_k.speed), .den(it_k.mag), .side_in(it_k),
    .out_valid(vl), .qa(qd_x), .qb(qd_y), .side_out(side_l)
  );
  assign it_l = sfu_pkg::item_t'(side_l);

  // ---------------- stage D1: desired velocity
  sfu_pkg::item_t it_d1, it_m;
  logic           vm;

  always_comb begin
    it_d1 = it_l;
    if (it_l.mag == '0) begin
      it_d1.px = '0;
      it_d1.py = '0;
    end else begin
      it_d1.px = sfu_pkg::sat32(sfu_pkg::signed_q(qd_x, it_l.dx[31]));
      it_d1.py = sfu_pkg::sat32(sfu_pkg::signed_q(qd_y, it_l.dy[31]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vl;
    end
    if (en) it_m <= it_d1;
  end

  // ---------------- stage D2: raw force
  sfu_pkg::item_t it_d2, it_n;
  logic           vn;

  always_comb begin
    it_d2    = it_m;
    it_d2.dx = sfu_pkg::sat32(44'(it_m.px) - 44'(it_m.svx));
    it_d2.dy = sfu_pkg::sat32(44'(it_m.py) - 44'(it_m.svy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= vm;
    end
    if (en) it_n <= it_d2;
  end

  // ---------------- force magnitude and clamp scale
  logic [IW-1:0]  side_o, side_p;
  sfu_pkg::item_t it_o, it_pp, md_e_side;
  logic [31:0]    mag_o;
  logic           vo, vp;
  logic [40:0]    qf_x, qf_y;

  sfu_mag #(.SW(IW)) u_mag_d (
    .clk, .rst, .en, .in_valid(vn), .x(it_n.dx), .y(it_n.dy), .side_in(it_n),
    .out_valid(vo), .mag(mag_o), .side_out(side_o)
  );
  assign it_o = sfu_pkg::item_t'(side_o);

  always_comb begin
    md_e_side     = it_o;
    md_e_side.mag = mag_o;
  end

  sfu_muldiv #(.SW(IW)) u_md_clamp (
    .clk, .rst, .en, .in_valid(vo),
    .a(sfu_pkg::abs32(it_o.dx)), .b(sfu_pkg::abs32(it_o.dy)),
    .num({1'b0, force_cap}), .den(mag_o), .side_in(md_e_side),
    .out_valid(vp), .qa(qf_x), .qb(qf_y), .side_out(side_p)
  );
  assign it_pp = sfu_pkg::item_t'(side_p);

  // ---------------- output register
  logic signed [31:0] fx, fy;

  always_comb begin
    if (!it_pp.ok) begin
      fx = '0;
      fy = '0;
    end else if (it_pp.mag > {1'b0, force_cap}) begin
      fx = sfu_pkg::sat32(sfu_pkg::signed_q(qf_x, it_pp.dx[31]));
      fy = sfu_pkg::sat32(sfu_pkg::signed_q(qf_y, it_pp.dy[31]));
    end else begin
      fx = it_pp.dx;
      fy = it_pp.dy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vp;
    end
    if (en) begin
      m_tdata <= {fy, fx};
      m_tuser <= it_pp.ok;
    end
  end

endmodule

### rtl/sfu_checker.sv
// Port-level checker for the steering force unit, bound to the top level.
`include "steering_force_unit_macros.svh"

module sfu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // a held result keeps its payload
  `SFU_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")

  // a skipped item carries a zero force
  `SFU_ASSERT(a_skip_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata == 64'd0, "skipped item with nonzero force")

  // a held output stalls the whole pipeline, input included
  `SFU_ASSERT(a_stall_in, clk, rst, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")

  // reset empties the output
  `SFU_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind steering_force_unit sfu_checker u_sfu_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

### tb/sfu_checker.sv
// Scoreboard for the steering force unit: predicts each force and compares results.
`timescale 1ns / 1ps

module sfu_scoreboard (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [327:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic         m_tuser,
  output int           errors,
  output int           outstanding,
  output int           n_checked,
  output int           n_skipped
);

  typedef struct {
    longint x;
    longint y;
  } vec_t;

  typedef struct {
    logic [31:0]     fx;
    logic [31:0]     fy;
    logic            computed;
    sfu_pkg::cmd_t   cmd;
  } force_t;

  localparam longint unsigned NEAR_ZERO = 7;
  localparam longint unsigned LEAD_CAP  = 64'd1 << 40;

  force_t      force_q[$];
  logic [30:0] speed_lim;
  logic [30:0] force_lim;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vec_t diff(input vec_t a, input vec_t b);
    vec_t r;
    r.x = sat(a.x - b.x);
    r.y = sat(a.y - b.y);
    return r;
  endfunction

  function automatic vec_t sum(input vec_t a, input vec_t b);
    vec_t r;
    r.x = sat(a.x + b.x);
    r.y = sat(a.y + b.y);
    return r;
  endfunction

  function automatic longint unsigned length(input vec_t v);
    longint unsigned sx;
    longint unsigned sy;
    sx = v.x * v.x;
    sy = v.y * v.y;
    return isqrt(sx + sy);
  endfunction

  // component * num / den, truncated toward zero, quotient capped at 2^40
  function automatic longint ratio(input longint v, input longint unsigned num,
                                   input longint unsigned den);
    longint unsigned a;
    longint unsigned q;
    a = (v < 0) ? longint'(-v) : longint'(v);
    q = (a * num) / den;
    if (q > LEAD_CAP) q = LEAD_CAP;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic vec_t rescale(input vec_t v, input longint unsigned num,
                                   input longint unsigned den);
    vec_t r;
    r.x = sat(ratio(v.x, num, den));
    r.y = sat(ratio(v.y, num, den));
    return r;
  endfunction

  function automatic vec_t toward(input vec_t to, input vec_t from, input longint unsigned s);
    vec_t d;
    vec_t z;
    longint unsigned m;
    d = diff(to, from);
    m = length(d);
    z.x = 0;
    z.y = 0;
    if (m == 0) return z;
    return rescale(d, s, m);
  endfunction

  // Lead point of a moving target
  function automatic vec_t intercept(input vec_t tgt, input vec_t tvel, input vec_t src);
    longint unsigned m;
    vec_t r;
    m = length(diff(tgt, src));
    if (speed_lim == 0) return tgt;
    r.x = sat(tgt.x + ratio(tvel.x, m, speed_lim));
    r.y = sat(tgt.y + ratio(tvel.y, m, speed_lim));
    return r;
  endfunction

  function automatic logic arrival(input vec_t tgt, input vec_t src,
                                   input longint unsigned slow, output vec_t want);
    vec_t d;
    longint unsigned m;
    longint unsigned spd;
    d = diff(tgt, src);
    m = length(d);
    want.x = 0;
    want.y = 0;
    if (m < NEAR_ZERO) return 1'b0;
    if (slow == 0 || m >= slow) spd = speed_lim;
    else spd = (m * speed_lim) / slow;
    want = rescale(d, spd, m);
    return 1'b1;
  endfunction

  function automatic vec_t standoff_point(input vec_t base, input vec_t src,
                                          input longint unsigned reach);
    vec_t p;
    vec_t off;
    longint unsigned m;
    p = diff(src, base);
    m = length(p);
    if (m >= NEAR_ZERO) begin
      off = rescale(p, reach, m);
    end else begin
      off.x = 0;
      off.y = sfu_pkg::ONE_Q16;
    end
    return sum(base, off);
  endfunction

  function automatic force_t steer(input logic [327:0] d);
    vec_t tgt, tvel, src, svel, want, lead, f;
    longint unsigned reach, slow, fm;
    logic ok;
    force_t r;
    r.cmd = sfu_pkg::cmd_t'(d[2:0]);
    tgt.x  = longint'(signed'(d[34:3]));
    tgt.y  = longint'(signed'(d[66:35]));
    tvel.x = longint'(signed'(d[98:67]));
    tvel.y = longint'(signed'(d[130:99]));
    src.x  = longint'(signed'(d[162:131]));
    src.y  = longint'(signed'(d[194:163]));
    svel.x = longint'(signed'(d[226:195]));
    svel.y = longint'(signed'(d[258:227]));
    reach = d[289:259];
    slow = d[320:290];
    want.x = 0;
    want.y = 0;
    ok = 1'b1;
    case (r.cmd)
      sfu_pkg::CMD_SEEK:       want = toward(tgt, src, speed_lim);
      sfu_pkg::CMD_FLEE:       want = toward(src, tgt, speed_lim);
      sfu_pkg::CMD_ARRIVE:     ok = arrival(tgt, src, slow, want);
      sfu_pkg::CMD_PURSUE:     want = toward(intercept(tgt, tvel, src), src, speed_lim);
      sfu_pkg::CMD_EVADE:      want = toward(src, intercept(tgt, tvel, src), speed_lim);
      sfu_pkg::CMD_OFS_PURSUE: begin
        lead = intercept(tgt, tvel, src);
        want = toward(standoff_point(lead, src, reach), src, speed_lim);
      end
      sfu_pkg::CMD_OFS_ARRIVE: ok = arrival(standoff_point(tgt, src, reach), src, slow, want);
      default:                 ok = 1'b0;
    endcase
    if (ok) begin
      f = diff(want, svel);
      fm = length(f);
      if (fm > force_lim) f = rescale(f, force_lim, fm);
    end else begin
      f.x = 0;
      f.y = 0;
    end
    r.fx = f.x[31:0];
    r.fy = f.y[31:0];
    r.computed = ok;
    return r;
  endfunction

  task automatic report(input string what, input force_t e, input logic [31:0] got);
    $display("%0t mismatch on %s (%s): expected %h got %h", $realtime, what, e.cmd.name(),
             what == "computed" ? 32'(e.computed) : (what == "force_x" ? e.fx : e.fy), got);
    errors++;
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    force_t e;
    if (rst) begin
      force_q.delete();
      speed_lim <= sfu_pkg::REG_RESET;
      force_lim <= sfu_pkg::REG_RESET;
      errors <= 0;
      outstanding <= 0;
      n_checked <= 0;
      n_skipped <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == sfu_pkg::REG_SPEED_MAX) speed_lim <= cfg_data;
        else force_lim <= cfg_data;
      end
      if (s_tvalid && s_tready) force_q.push_back(steer(s_tdata));
      if (m_tvalid && m_tready) begin
        if (force_q.size() == 0) begin
          $display("%0t result transaction with nothing expected", $realtime);
          errors++;
        end else begin
          e = force_q.pop_front();
          n_checked <= n_checked + 1;
          if (!e.computed) n_skipped <= n_skipped + 1;
          if (m_tdata[31:0] !== e.fx) report("force_x", e, m_tdata[31:0]);
          if (m_tdata[63:32] !== e.fy) report("force_y", e, m_tdata[63:32]);
          if (m_tuser !== e.computed) report("computed", e, 32'(m_tuser));
        end
      end
      outstanding <= force_q.size();
    end
  end

endmodule

### tb/tb.sv
// Top of the steering force unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY   = 469;
  localparam int IDLE_MAX  = 20000;
  localparam int HOLD_LEN  = 1500;
  localparam logic [30:0] REG_TOP = 31'h7FFF_FFFF;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_index;
  logic [30:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [327:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic         m_tuser;
  int           errors;
  int           outstanding;
  int           n_checked;
  int           n_skipped;
  int           n_sent;
  int           idle_cycles;
  logic         hold_req;

  steering_force_unit dut (.*);
  sfu_scoreboard chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_MAX) begin
        $display("timeout with %0d results outstanding", outstanding);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall pattern picked at random from four modes, one long hold-off on request
  initial begin : rx
    int cyc;
    int mode;
    int hold_left;
    logic hold_seen;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) != 0);
        2: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [327:0] pack(input sfu_pkg::cmd_t c, input logic [31:0] tx, ty,
                                        tvx, tvy, sx, sy, svx, svy,
                                        input logic [30:0] so, sl);
    return {7'd0, sl, so, svy, svx, sy, sx, tvy, tvx, ty, tx, c};
  endfunction

  // One coordinate from a magnitude class
  function automatic logic [31:0] coord(input int cls);
    case (cls)
      0: return $urandom;
      1: return $urandom_range(0, 1 << 21) - (1 << 20);
      2: return $urandom_range(0, 16) - 8;
      3: case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0;
        3: return 32'h1;
        default: return 32'hFFFF_FFFF;
      endcase
      default: return $urandom_range(0, 1 << 25) - (1 << 24);
    endcase
  endfunction

  function automatic logic [30:0] dist31();
    case ($urandom_range(0, 3))
      0: return 31'd0;
      1: return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 22));
    endcase
  endfunction

  function automatic logic [327:0] random_agent();
    int cls;
    logic [31:0] tx, ty, sx, sy;
    sfu_pkg::cmd_t c;
    c = sfu_pkg::cmd_t'($urandom_range(0, 7));
    cls = $urandom_range(0, 9);
    cls = (cls < 2) ? 0 : (cls < 6) ? 1 : (cls < 7) ? 3 : 4;
    tx = coord(cls);
    ty = coord(cls);
    if ($urandom_range(0, 5) == 0) begin
      // source within a few LSBs of the target
      sx = tx + coord(2);
      sy = ty + coord(2);
    end else begin
      sx = coord(cls);
      sy = coord(cls);
    end
    return pack(c, tx, ty, coord(cls), coord(cls), sx, sy, coord(cls), coord(cls),
                dist31(), dist31());
  endfunction

  task automatic send(input logic [327:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(input int count, input logic halve);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        burst = $urandom_range(1, 40);
      end
      if (halve && i == count / 2) drain();
      send(random_agent());
      burst--;
    end
  endtask

  initial begin : stim
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    rst = 1'b1;
    hold_req = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sfu_pkg::REG_SPEED_MAX;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    n_sent = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed agents under the reset settings
    send(pack(sfu_pkg::CMD_SEEK, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0, 0));
    send(pack(sfu_pkg::CMD_FLEE, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h1_0000, 0,
              0, 0));
    send(pack(sfu_pkg::CMD_SEEK, 5, 5, 0, 0, 5, 5, 0, 0, 0, 0));            // zero-length
    send(pack(sfu_pkg::CMD_SEEK, mx, mx, mx, mx, mn, mn, mn, mn, REG_TOP, REG_TOP));
    send(pack(sfu_pkg::CMD_FLEE, mn, mn, mn, mn, mx, mx, mx, mx, REG_TOP, REG_TOP));
    send(pack(sfu_pkg::CMD_ARRIVE, 3, 2, 0, 0, 0, 0, 0, 0, 0, 0));          // too close
    send(pack(sfu_pkg::CMD_ARRIVE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // at threshold
    send(pack(sfu_pkg::CMD_ARRIVE, 32'h2_0000, 0, 0, 0, 0, 0, 0, 0, 0, 31'h8_0000));
    send(pack(sfu_pkg::CMD_ARRIVE, 32'h9_0000, 0, 0, 0, 0, 0, 0, 0, 0, 31'h8_0000));
    send(pack(sfu_pkg::CMD_ARRIVE, mx, mn, 0, 0, mn, mx, mx, mn, 0, REG_TOP));
    send(pack(sfu_pkg::CMD_PURSUE, 32'h4_0000, 0, 0, 32'h1_0000, 0, 0, 0, 0, 0, 0));
    send(pack(sfu_pkg::CMD_PURSUE, mx, mx, mx, mx, mn, mn, 0, 0, 0, 0));
    send(pack(sfu_pkg::CMD_EVADE, 32'h4_0000, 0, 0, 32'h1_0000, 0, 0, 0, 0, 0, 0));
    send(pack(sfu_pkg::CMD_EVADE, mn, mn, mn, mn, mx, mx, mx, mx, 0, 0));
    send(pack(sfu_pkg::CMD_OFS_PURSUE, 32'h4_0000, 0, 0, 0, 0, 0, 0, 0, 31'h1_0000, 0));
    send(pack(sfu_pkg::CMD_OFS_PURSUE, 9, 9, 0, 0, 9, 9, 0, 0, 31'h1_0000, 0)); // fallback
    send(pack(sfu_pkg::CMD_OFS_ARRIVE, 32'h4_0000, 0, 0, 0, 0, 0, 0, 0, 31'h1_0000,
              31'h2_0000));
    send(pack(sfu_pkg::CMD_OFS_ARRIVE, 0, 0, 0, 0, 2, 1, 0, 0, REG_TOP, 0));    // fallback
    send(pack(sfu_pkg::CMD_OFS_ARRIVE, mx, mx, 0, 0, mn, mn, mx, mx, REG_TOP, REG_TOP));
    send(pack(sfu_pkg::CMD_NOP, mx, mx, mx, mx, mx, mx, mx, mx, REG_TOP, REG_TOP));
    send(pack(sfu_pkg::CMD_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Zero speed: no lead on prediction, zero force limit
    write_reg(sfu_pkg::REG_SPEED_MAX, 31'd0);
    write_reg(sfu_pkg::REG_FORCE_MAX, 31'd0);
    send(pack(sfu_pkg::CMD_PURSUE, 32'h4_0000, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0));
    send(pack(sfu_pkg::CMD_OFS_PURSUE, 32'h4_0000, 0, 32'h1_0000, 0, 0, 0, 0, 0,
              31'h1_0000, 0));
    random_run(80, 1'b0);
    drain();

    // Largest limits
    write_reg(sfu_pkg::REG_SPEED_MAX, REG_TOP);
    write_reg(sfu_pkg::REG_FORCE_MAX, REG_TOP);
    random_run(150, 1'b1);
    drain();

    // Typical game settings; the receiver holds off long enough to fill the pipeline
    write_reg(sfu_pkg::REG_SPEED_MAX, 31'h3_0000);
    write_reg(sfu_pkg::REG_FORCE_MAX, 31'h0_8000);
    hold_req = 1'b1;
    random_run(550, 1'b0);
    drain();

    // Random limits
    write_reg(sfu_pkg::REG_SPEED_MAX, 31'($urandom_range(0, 1 << 24)));
    write_reg(sfu_pkg::REG_FORCE_MAX, 31'($urandom));
    random_run(150, 1'b1);
    drain();

    $display("Run covered %0d agent updates over all seven steering modes and the idle code,",
             n_sent);
    $display("%0d force results checked, %0d of them not computed.", n_checked, n_skipped);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
